### design/lpb_pkg.sv
// Shared types, codes and microcode table of the LED pixel buffer engine.
`default_nettype none

package lpb_pkg;

   typedef logic [2:0] action_type;
   typedef logic [3:0] step_type;
   typedef logic [2:0] seq_type;
   typedef logic [1:0] dsel_type;
   typedef logic [1:0] rsel_type;

   localparam action_type ACT_SET      = 3'd0;
   localparam action_type ACT_FILL     = 3'd1;
   localparam action_type ACT_ROT_DOWN = 3'd2;
   localparam action_type ACT_ROT_UP   = 3'd3;
   localparam action_type ACT_SHOW     = 3'd4;

   localparam step_type STEP_IDLE = 4'd0;
   localparam step_type STEP_SET  = 4'd1;
   localparam step_type STEP_FILL = 4'd2;
   localparam step_type STEP_RD0  = 4'd3;
   localparam step_type STEP_RD1  = 4'd4;
   localparam step_type STEP_RD2  = 4'd5;
   localparam step_type STEP_RD3  = 4'd6;
   localparam step_type STEP_RU0  = 4'd7;
   localparam step_type STEP_RU1  = 4'd8;
   localparam step_type STEP_RU2  = 4'd9;
   localparam step_type STEP_SH0  = 4'd10;
   localparam step_type STEP_SH1  = 4'd11;

   localparam seq_type SEQ_NEXT      = 3'd0;
   localparam seq_type SEQ_GOTO      = 3'd1;
   localparam seq_type SEQ_LOOP_LAST = 3'd2;
   localparam seq_type SEQ_LOOP_PEN  = 3'd3;
   localparam seq_type SEQ_DISPATCH  = 3'd4;

   localparam dsel_type WD_COL  = 2'd0;
   localparam dsel_type WD_RD   = 2'd1;
   localparam dsel_type WD_HOLD = 2'd2;

   localparam rsel_type RD_NONE = 2'd0;
   localparam rsel_type RD_CNT  = 2'd1;
   localparam rsel_type RD_LAST = 2'd2;

   typedef struct packed {
      logic     take;
      logic     wen;
      logic     wa_idx;
      dsel_type wdsel;
      rsel_type rsel;
      logic     rinc;
      logic     winc;
      logic     hold_ld;
      logic     emit;
      seq_type  seq;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic       req_valid;
      action_type action;
      logic       cnt_last;
      logic       cnt_pen;
      logic       stall;
   } seq_status_type;

   function automatic step_type entry_step(action_type act);
      step_type s;
      s = STEP_IDLE;
      unique case (act)
         ACT_SET:      s = STEP_SET;
         ACT_FILL:     s = STEP_FILL;
         ACT_ROT_DOWN: s = STEP_RD0;
         ACT_ROT_UP:   s = STEP_RU0;
         ACT_SHOW:     s = STEP_SH0;
         default:      s = STEP_IDLE;
      endcase
      return s;
   endfunction

   function automatic ctrl_word_type ucode(step_type s);
      ctrl_word_type w;
      w = '0;
      w.target = STEP_IDLE;
      unique case (s)
         STEP_IDLE: begin
            w.take = 1'b1;
            w.seq  = SEQ_DISPATCH;
         end
         STEP_SET: begin
            w.wen    = 1'b1;
            w.wa_idx = 1'b1;
            w.wdsel  = WD_COL;
            w.seq    = SEQ_GOTO;
         end
         STEP_FILL: begin
            w.wen   = 1'b1;
            w.wdsel = WD_COL;
            w.winc  = 1'b1;
            w.seq   = SEQ_LOOP_LAST;
         end
         STEP_RD0: begin
            w.rsel = RD_CNT;
            w.rinc = 1'b1;
            w.seq  = SEQ_NEXT;
         end
         STEP_RD1: begin
            w.hold_ld = 1'b1;
            w.rsel    = RD_CNT;
            w.rinc    = 1'b1;
            w.seq     = SEQ_NEXT;
         end
         STEP_RD2: begin
            w.wen    = 1'b1;
            w.wdsel  = WD_RD;
            w.winc   = 1'b1;
            w.rsel   = RD_CNT;
            w.rinc   = 1'b1;
            w.seq    = SEQ_LOOP_PEN;
            w.target = STEP_RD3;
         end
         STEP_RD3: begin
            w.wen   = 1'b1;
            w.wdsel = WD_HOLD;
            w.seq   = SEQ_GOTO;
         end
         STEP_RU0: begin
            w.rsel = RD_LAST;
            w.seq  = SEQ_NEXT;
         end
         STEP_RU1: begin
            w.wen   = 1'b1;
            w.wdsel = WD_RD;
            w.winc  = 1'b1;
            w.rsel  = RD_CNT;
            w.rinc  = 1'b1;
            w.seq   = SEQ_NEXT;
         end
         STEP_RU2: begin
            w.wen   = 1'b1;
            w.wdsel = WD_RD;
            w.winc  = 1'b1;
            w.rsel  = RD_CNT;
            w.rinc  = 1'b1;
            w.seq   = SEQ_LOOP_LAST;
         end
         STEP_SH0: begin
            w.rsel = RD_CNT;
            w.rinc = 1'b1;
            w.seq  = SEQ_NEXT;
         end
         STEP_SH1: begin
            w.emit = 1'b1;
            w.winc = 1'b1;
            w.rsel = RD_CNT;
            w.rinc = 1'b1;
            w.seq  = SEQ_LOOP_LAST;
         end
         default: begin
            w.seq = SEQ_GOTO;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/lpb_req_if.sv
// Command channel: valid/ready handshake with one command word.
`default_nettype none

interface lpb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [5:0] pixel_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, action, pixel_index, red, green, blue, input ready);
   modport sink   (input valid, action, pixel_index, red, green, blue, output ready);
endinterface

`default_nettype wire

### design/lpb_rsp_if.sv
// Pixel output channel: valid/ready handshake with one pixel word.
`default_nettype none

interface lpb_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] out_index;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       out_last;

   modport source (output valid, out_index, out_red, out_green, out_blue, out_last,
                   input ready);
   modport sink   (input valid, out_index, out_red, out_green, out_blue, out_last,
                   output ready);
endinterface

`default_nettype wire

### design/lpb_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none

module lpb_seq
   import lpb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ctrl_word_type  cw
);

   step_type step_ff;
   step_type step_in;

   assign cw = ucode(step_ff);

   always_comb begin
      step_in = step_ff;
      if (!status.stall) begin
         unique case (cw.seq)
            SEQ_NEXT:      step_in = step_ff + 4'd1;
            SEQ_GOTO:      step_in = cw.target;
            SEQ_LOOP_LAST: step_in = status.cnt_last ? cw.target : step_ff;
            SEQ_LOOP_PEN:  step_in = status.cnt_pen ? cw.target : step_ff;
            SEQ_DISPATCH:  step_in = status.req_valid ? entry_step(status.action) : STEP_IDLE;
            default:       step_in = STEP_IDLE;
         endcase
      end
   end

   // reset starts the fill program with a zero color to clear the store
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FILL;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

### design/led_pixel_buffer_engine.sv
// LED pixel buffer engine: microcoded frame store for an RGB LED strip.
// Actions: set, fill, rotate down, rotate up and show; show also waits on output stalls.
// Each microcode step performs at most one memory write. Unused action codes are
// accepted and leave the store unchanged.
// Reset: synchronous; a clearing pass zeroes the store, and commands are accepted
// after it ends.
`default_nettype none

module led_pixel_buffer_engine
   import lpb_pkg::*;
#(
   parameter int PIXEL_COUNT = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lpb_req_if.sink     req_ch,
   lpb_rsp_if.source   rsp_ch
);

   localparam int IW = (PIXEL_COUNT > 2) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [IW-1:0] LastIdx = IW'(PIXEL_COUNT - 1);
   localparam logic [IW-1:0] PenIdx  = IW'(PIXEL_COUNT - 2);
   localparam logic [6:0]    CountW  = 7'(PIXEL_COUNT);

   ctrl_word_type  cw;
   seq_status_type status;

   logic [23:0] mem [PIXEL_COUNT];

   logic [IW-1:0] rcnt_ff, rcnt_in;
   logic [IW-1:0] wcnt_ff, wcnt_in;
   logic [23:0]   col_ff;
   logic [5:0]    idx_ff;
   logic [23:0]   hold_ff;
   logic [23:0]   rd_ff;

   logic          ovalid_ff;
   logic [5:0]    oidx_ff;
   logic [23:0]   ocol_ff;
   logic          olast_ff;

   logic          accept;
   logic          stall;
   logic          idx_ok;
   logic          wen;
   logic          ren;
   logic [IW-1:0] waddr;
   logic [IW-1:0] raddr;
   logic [23:0]   wdata;

   lpb_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   assign req_ch.ready = cw.take;
   assign accept = req_ch.valid && cw.take;
   assign stall  = cw.emit && ovalid_ff && !rsp_ch.ready;

   assign status.req_valid = req_ch.valid;
   assign status.action    = req_ch.action;
   assign status.cnt_last  = (wcnt_ff == LastIdx);
   assign status.cnt_pen   = (wcnt_ff == PenIdx);
   assign status.stall     = stall;

   assign idx_ok = ({1'b0, idx_ff} < CountW);
   assign waddr  = cw.wa_idx ? idx_ff[IW-1:0] : wcnt_ff;
   assign wen    = cw.wen && !stall && (!cw.wa_idx || idx_ok);
   assign raddr  = (cw.rsel == RD_LAST) ? LastIdx : rcnt_ff;
   assign ren    = (cw.rsel != RD_NONE) && !stall;

   always_comb begin
      unique case (cw.wdsel)
         WD_COL:  wdata = col_ff;
         WD_RD:   wdata = rd_ff;
         WD_HOLD: wdata = hold_ff;
         default: wdata = col_ff;
      endcase
   end

   // read returns the old entry when the same address is written
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rd_ff <= mem[raddr];
      end
   end

   always_comb begin
      rcnt_in = rcnt_ff;
      wcnt_in = wcnt_ff;
      if (accept) begin
         rcnt_in = '0;
         wcnt_in = '0;
      end else if (!stall) begin
         if (cw.rinc) begin
            rcnt_in = rcnt_ff + 1'b1;
         end
         if (cw.winc) begin
            wcnt_in = wcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcnt_ff <= '0;
         wcnt_ff <= '0;
         col_ff  <= '0;
      end else begin
         rcnt_ff <= rcnt_in;
         wcnt_ff <= wcnt_in;
         if (accept) begin
            col_ff <= {req_ch.red, req_ch.green, req_ch.blue};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= req_ch.pixel_index;
      end
      if (cw.hold_ld && !stall) begin
         hold_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cw.emit && !stall) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.emit && !stall) begin
         oidx_ff  <= 6'(wcnt_ff);
         ocol_ff  <= rd_ff;
         olast_ff <= status.cnt_last;
      end
   end

   assign rsp_ch.valid     = ovalid_ff;
   assign rsp_ch.out_index = oidx_ff;
   assign rsp_ch.out_red   = ocol_ff[23:16];
   assign rsp_ch.out_green = ocol_ff[15:8];
   assign rsp_ch.out_blue  = ocol_ff[7:0];
   assign rsp_ch.out_last  = olast_ff;

endmodule

`default_nettype wire
